// ===== sv/rxfd_pkg.sv =====
// rxfd_pkg: shared sizes, codes and types for the receive fifo deframer
// no dependencies; imported by rxfd_fifo, rxfd_deframer and rx_fifo_packet_deframer
`default_nettype none

package rxfd_pkg;

	localparam int FIFO_DEPTH   = 32;
	localparam int PACKET_LIMIT = 32;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
	localparam int IDX_W = (PACKET_LIMIT > 1) ? $clog2(PACKET_LIMIT) : 1;

	localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PACKET_LIMIT - 1);

	localparam logic [7:0] START_MARKER_RST = 8'd60;
	localparam logic [7:0] END_MARKER_RST   = 8'd62;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POLL = 1'b1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;

	typedef enum logic [2:0] {
		ST_PUSHED     = 3'd0,
		ST_PUSH_DROP  = 3'd1,
		ST_POLL_EMPTY = 3'd2,
		ST_IGNORED    = 3'd3,
		ST_PKT_START  = 3'd4,
		ST_PAYLOAD    = 3'd5,
		ST_COMPLETE   = 3'd6
	} status_t;

	typedef struct packed {
		logic             empty;
		logic             full;
		logic [LVL_W-1:0] level_nxt;
	} fifo_stat_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] index;
		logic [7:0]       data;
		logic [IDX_W-1:0] length;
	} dfr_res_t;

	function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
		ptr_adv = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== sv/rxfd_fifo.sv =====
// rxfd_fifo: ring buffer of received bytes that drops the oldest byte when full
// depends on rxfd_pkg for depth, pointer width and status struct
`default_nettype none

module rxfd_fifo
	import rxfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic       pop,
	input  wire logic [7:0] wr_data,
	output logic [7:0]      rd_data,
	output fifo_stat_t      stat
);

	logic [7:0]       mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr_nxt, rd_ptr_nxt;
	logic [LVL_W-1:0] count_nxt;
	logic             full;
	logic [7:0]       rd_data_q;

	assign full    = (count_q == LVL_FULL);
	assign rd_data = rd_data_q;

	always_comb begin
		wr_ptr_nxt = wr_ptr_q;
		rd_ptr_nxt = rd_ptr_q;
		count_nxt  = count_q;
		if (push) begin
			wr_ptr_nxt = ptr_adv(wr_ptr_q);
			if (full) begin
				// oldest word is overwritten, read side follows the write side
				rd_ptr_nxt = ptr_adv(wr_ptr_q);
			end else begin
				count_nxt = count_q + LVL_W'(1);
			end
		end else if (pop) begin
			rd_ptr_nxt = ptr_adv(rd_ptr_q);
			count_nxt  = count_q - LVL_W'(1);
		end
	end

	assign stat.empty     = (count_q == '0);
	assign stat.full      = full;
	assign stat.level_nxt = count_nxt;

	// head word is fetched ahead at the next read pointer, with bypass on write
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (push && (wr_ptr_q == rd_ptr_nxt)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem[rd_ptr_nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_nxt;
			rd_ptr_q <= rd_ptr_nxt;
			count_q  <= count_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rxfd_deframer.sv =====
// rxfd_deframer: start/end marker packet deframer fed one word per pop
// depends on rxfd_pkg for status codes, slot width and result struct
`default_nettype none

module rxfd_deframer
	import rxfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       pop,
	input  wire logic [7:0] data,
	input  wire logic [7:0] start_marker,
	input  wire logic [7:0] end_marker,
	output dfr_res_t        res
);

	logic             in_pkt_q, in_pkt_nxt;
	logic [IDX_W-1:0] idx_q, idx_nxt;

	always_comb begin
		in_pkt_nxt = in_pkt_q;
		idx_nxt    = idx_q;
		res.status = ST_IGNORED;
		res.index  = '0;
		res.data   = '0;
		res.length = '0;
		if (in_pkt_q) begin
			if (data == end_marker) begin
				res.status = ST_COMPLETE;
				res.index  = idx_q;
				res.length = idx_q;
				in_pkt_nxt = 1'b0;
			end else begin
				res.status = ST_PAYLOAD;
				res.index  = idx_q;
				res.data   = data;
				// index sticks at the last slot once the limit is reached
				if (idx_q != IDX_LAST) begin
					idx_nxt = idx_q + IDX_W'(1);
				end
			end
		end else if (data == start_marker) begin
			res.status = ST_PKT_START;
			idx_nxt    = '0;
			in_pkt_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pkt_q <= 1'b0;
			idx_q    <= '0;
		end else if (pop) begin
			in_pkt_q <= in_pkt_nxt;
			idx_q    <= idx_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rx_fifo_packet_deframer.sv =====
// rx_fifo_packet_deframer: top level of the serial receive fifo and packet deframer
// depends on rxfd_pkg, rxfd_fifo and rxfd_deframer
`default_nettype none

// Each input word is either a push of a received byte or a poll that pops one
// byte into the deframer; every word yields exactly one result word. A word
// is taken into an input register, handled combinationally against the fifo and
// deframer state, and lands in a result register; out_valid rises when the word
// moves from the input register into the result register, and one word can be
// accepted every cycle while the result side keeps up. in_ready drops only when the
// result register is held by out_ready low and the input register is occupied. The
// fifo holds 32 bytes and drops the oldest on overflow; the marker registers reset
// to '<' and '>' and may be rewritten through the cfg port, which is always ready.

module rx_fifo_packet_deframer
	import rxfd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 kind,
	input  wire logic [7:0]           rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [2:0]                status,
	output logic [IDX_W-1:0]          store_index,
	output logic [7:0]                store_byte,
	output logic [IDX_W-1:0]          packet_length,
	output logic [LVL_W-1:0]          fifo_level,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	logic [7:0]       start_marker_q, end_marker_q;
	logic             valid_s1;
	logic             kind_s1;
	logic [7:0]       rx_byte_s1;
	logic             adv;
	logic             push, pop;
	logic [7:0]       fifo_rd_data;
	fifo_stat_t       fifo_stat;
	dfr_res_t         dfr_res;
	logic             out_valid_q;
	status_t          status_q, status_nxt;
	logic [IDX_W-1:0] store_index_q, store_index_nxt;
	logic [7:0]       store_byte_q, store_byte_nxt;
	logic [IDX_W-1:0] packet_length_q, packet_length_nxt;
	logic [LVL_W-1:0] fifo_level_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_data;
				CFG_END_MARKER:   end_marker_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign push     = adv && (kind_s1 == KIND_PUSH);
	assign pop      = adv && (kind_s1 == KIND_POLL) && !fifo_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1    <= kind;
			rx_byte_s1 <= rx_byte;
		end
	end

	rxfd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.wr_data (rx_byte_s1),
		.rd_data (fifo_rd_data),
		.stat    (fifo_stat)
	);

	rxfd_deframer u_dfr (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop          (pop),
		.data         (fifo_rd_data),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.res          (dfr_res)
	);

	always_comb begin
		status_nxt        = dfr_res.status;
		store_index_nxt   = dfr_res.index;
		store_byte_nxt    = dfr_res.data;
		packet_length_nxt = dfr_res.length;
		if (kind_s1 == KIND_PUSH || fifo_stat.empty) begin
			store_index_nxt   = '0;
			store_byte_nxt    = '0;
			packet_length_nxt = '0;
			if (kind_s1 == KIND_POLL) begin
				status_nxt = ST_POLL_EMPTY;
			end else if (fifo_stat.full) begin
				status_nxt = ST_PUSH_DROP;
			end else begin
				status_nxt = ST_PUSHED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q        <= status_nxt;
			store_index_q   <= store_index_nxt;
			store_byte_q    <= store_byte_nxt;
			packet_length_q <= packet_length_nxt;
			fifo_level_q    <= fifo_stat.level_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign store_index   = store_index_q;
	assign store_byte    = store_byte_q;
	assign packet_length = packet_length_q;
	assign fifo_level    = fifo_level_q;

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a held result");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fifo_level <= LVL_FULL))
		else $error("fifo level above depth");

	a_complete_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_COMPLETE) |->
		(store_byte == 8'd0 && store_index == packet_length))
		else $error("completion word with bad terminator or length");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_stat.empty)
		else $error("pop from empty fifo");

endmodule

`default_nettype wire
